>>> rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg: shared definitions of the printf specifier parser
// Status codes, character constants and character class helpers.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned NUM_BITS_DEFAULT = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NOT_START = 2'd2
  } status_e;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LC_C    = 8'h63;
  localparam logic [7:0] CH_LC_S    = 8'h73;
  localparam logic [7:0] CH_LC_P    = 8'h70;
  localparam logic [7:0] CH_LC_D    = 8'h64;
  localparam logic [7:0] CH_LC_I    = 8'h69;
  localparam logic [7:0] CH_LC_U    = 8'h75;
  localparam logic [7:0] CH_LC_X    = 8'h78;
  localparam logic [7:0] CH_UC_X    = 8'h58;

  function automatic logic is_conv(input logic [7:0] c);
    return c inside {CH_LC_C, CH_LC_S, CH_LC_P, CH_LC_D, CH_LC_I, CH_LC_U,
                     CH_LC_X, CH_UC_X, CH_PERCENT};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_flag_char(input logic [7:0] c);
    return is_digit(c) || (c inside {CH_SPACE, CH_HASH, CH_PLUS, CH_MINUS, CH_DOT});
  endfunction

endpackage

>>> rtl/pfs_in_if.sv
// ----------------------------------------------------------------------------
// pfs_in_if: character channel of the printf specifier parser
// One format-string byte per request, with a flag marking a specifier start.
// ----------------------------------------------------------------------------
interface pfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

>>> rtl/pfs_out_if.sv
// ----------------------------------------------------------------------------
// pfs_out_if: record channel of the printf specifier parser
// One parsed specifier record per request.
// ----------------------------------------------------------------------------
interface pfs_out_if #(
  parameter int unsigned NUM_BITS = pfs_pkg::NUM_BITS_DEFAULT
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [7:0]                 conv_type;
  logic                       zero_pad;
  logic                       left_align;
  logic                       force_sign;
  logic                       space_sign;
  logic                       alt_form;
  logic [NUM_BITS-1:0]        field_width;
  logic signed [NUM_BITS:0]   precision_value;

  modport source (output valid, output status, output conv_type, output zero_pad,
                  output left_align, output force_sign, output space_sign,
                  output alt_form, output field_width, output precision_value,
                  input ready);
  modport sink   (input valid, input status, input conv_type, input zero_pad,
                  input left_align, input force_sign, input space_sign,
                  input alt_form, input field_width, input precision_value,
                  output ready);
endinterface

>>> rtl/printf_spec_parser_top.sv
// ----------------------------------------------------------------------------
// printf_spec_parser_top: streaming printf conversion specifier parser
// Collects flags, width and precision and emits one record per specifier.
// ----------------------------------------------------------------------------
// The parser takes one format-string byte per clock cycle. A byte is accepted
// whenever the output register is empty or its record is being taken in the
// same cycle, so a steady stream runs at one byte per cycle; a record appears
// on the output in the cycle after the byte that completes it. It comes from
// the single parse register stage, whose update (flag logic and the saturating
// multiply-by-ten of the width or precision run) is combinational.
// Width and precision saturate at 2**NUM_BITS - 1; precision reads -1 when no
// dot was seen.
module printf_spec_parser_top #(
  parameter int unsigned NUM_BITS = pfs_pkg::NUM_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfs_in_if.sink     in_i,
  pfs_out_if.source  out_o
);

  localparam int unsigned AccW = NUM_BITS + 4;
  localparam logic [NUM_BITS-1:0] FieldMax = {NUM_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FLAGS,
    MODE_WIDTH,
    MODE_PREC
  } mode_e;

  // Flag bit positions within the flag vector.
  localparam int unsigned FZero  = 0;
  localparam int unsigned FMinus = 1;
  localparam int unsigned FPlus  = 2;
  localparam int unsigned FSpace = 3;
  localparam int unsigned FHash  = 4;

  function automatic logic [NUM_BITS-1:0] acc_digit(input logic [NUM_BITS-1:0] v,
                                                    input logic [3:0] d);
    logic [AccW-1:0] n;
    n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{NUM_BITS{1'b0}}, d};
    return (n > {4'd0, FieldMax}) ? FieldMax : n[NUM_BITS-1:0];
  endfunction

  mode_e               mode_q, mode_d;
  logic [4:0]          flags_q, flags_d;
  logic [NUM_BITS-1:0] width_q, width_d;
  logic [NUM_BITS-1:0] prec_q, prec_d;
  logic                dot_q, dot_d;
  logic                frz_q, frz_d;
  // Snapshot stores: only read while their marker bit is set.
  logic [4:0]          snap_flags_q, snap_flags_d;
  logic [NUM_BITS-1:0] snap_width_q, snap_width_d;
  logic [4:0]          frz_flags_q, frz_flags_d;
  logic [NUM_BITS-1:0] frz_width_q, frz_width_d;
  logic                frz_dot_q, frz_dot_d;
  logic [NUM_BITS-1:0] frz_prec_q, frz_prec_d;

  logic                out_valid_q;
  pfs_pkg::status_e    status_q, status_d;
  logic [7:0]          conv_q, conv_d;
  logic [4:0]          oflags_q, oflags_d;
  logic [NUM_BITS-1:0] owidth_q, owidth_d;
  logic [NUM_BITS:0]   oprec_q, oprec_d;

  logic accept;
  logic emit;
  logic [7:0] c;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.ch;

  always_comb begin
    mode_d       = mode_q;
    flags_d      = flags_q;
    width_d      = width_q;
    prec_d       = prec_q;
    dot_d        = dot_q;
    frz_d        = frz_q;
    snap_flags_d = snap_flags_q;
    snap_width_d = snap_width_q;
    frz_flags_d  = frz_flags_q;
    frz_width_d  = frz_width_q;
    frz_dot_d    = frz_dot_q;
    frz_prec_d   = frz_prec_q;
    emit         = 1'b0;
    status_d     = pfs_pkg::ST_OK;
    conv_d       = 8'd0;
    oflags_d     = 5'd0;
    owidth_d     = '0;
    oprec_d      = '1;

    if (in_i.first) begin
      flags_d = 5'd0;
      width_d = '0;
      dot_d   = 1'b0;
      frz_d   = 1'b0;
      if (c == pfs_pkg::CH_PERCENT) begin
        mode_d = MODE_FLAGS;
      end else begin
        mode_d   = MODE_IDLE;
        emit     = 1'b1;
        status_d = pfs_pkg::ST_NOT_START;
      end
    end else if (mode_q == MODE_IDLE) begin
      // Stray bytes between specifiers are dropped.
    end else if (pfs_pkg::is_conv(c)) begin
      emit   = 1'b1;
      conv_d = c;
      if (dot_q && (c == pfs_pkg::CH_LC_P || c == pfs_pkg::CH_LC_C)) begin
        status_d = pfs_pkg::ST_MALFORMED;
        oflags_d = snap_flags_q;
        owidth_d = snap_width_q;
      end else if (frz_q) begin
        status_d = pfs_pkg::ST_MALFORMED;
        oflags_d = frz_flags_q;
        owidth_d = frz_width_q;
        oprec_d  = frz_dot_q ? {1'b0, frz_prec_q} : '1;
      end else begin
        oflags_d = flags_q;
        owidth_d = width_q;
        oprec_d  = dot_q ? {1'b0, prec_q} : '1;
      end
      mode_d  = MODE_IDLE;
      flags_d = 5'd0;
      width_d = '0;
      dot_d   = 1'b0;
      frz_d   = 1'b0;
    end else if (!pfs_pkg::is_flag_char(c)) begin
      emit     = 1'b1;
      status_d = pfs_pkg::ST_MALFORMED;
      mode_d   = MODE_IDLE;
      flags_d  = 5'd0;
      width_d  = '0;
      dot_d    = 1'b0;
      frz_d    = 1'b0;
    end else if (!frz_q) begin
      if (pfs_pkg::is_digit(c)) begin
        if (mode_q == MODE_PREC) begin
          prec_d = acc_digit(prec_q, c[3:0]);
        end else if (mode_q == MODE_WIDTH) begin
          width_d = acc_digit(width_q, c[3:0]);
        end else if (c == pfs_pkg::CH_ZERO && !flags_q[FMinus] && width_q == '0) begin
          flags_d[FZero] = 1'b1;
        end else begin
          width_d = {{(NUM_BITS-4){1'b0}}, c[3:0]};
          mode_d  = MODE_WIDTH;
        end
      end else begin
        mode_d = MODE_FLAGS;
        case (c)
          pfs_pkg::CH_MINUS: begin
            flags_d[FMinus] = 1'b1;
            flags_d[FZero]  = 1'b0;
          end
          pfs_pkg::CH_PLUS: begin
            flags_d[FPlus]  = 1'b1;
            flags_d[FSpace] = 1'b0;
          end
          pfs_pkg::CH_SPACE: begin
            if (flags_q[FPlus]) begin
              // Space after plus: keep the record as it stands for the error.
              frz_d       = 1'b1;
              frz_flags_d = flags_q;
              frz_width_d = width_q;
              frz_dot_d   = dot_q;
              frz_prec_d  = prec_q;
            end else begin
              flags_d[FSpace] = 1'b1;
            end
          end
          pfs_pkg::CH_HASH: begin
            flags_d[FHash] = 1'b1;
          end
          default: begin
            // Only the dot remains in the flag class here.
            if (!dot_q) begin
              dot_d        = 1'b1;
              snap_flags_d = flags_q;
              snap_width_d = width_q;
            end
            prec_d = '0;
            mode_d = MODE_PREC;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      flags_q     <= 5'd0;
      width_q     <= '0;
      prec_q      <= '0;
      dot_q       <= 1'b0;
      frz_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        flags_q <= flags_d;
        width_q <= width_d;
        prec_q  <= prec_d;
        dot_q   <= dot_d;
        frz_q   <= frz_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      snap_flags_q <= snap_flags_d;
      snap_width_q <= snap_width_d;
      frz_flags_q  <= frz_flags_d;
      frz_width_q  <= frz_width_d;
      frz_dot_q    <= frz_dot_d;
      frz_prec_q   <= frz_prec_d;
    end
    if (accept && emit) begin
      status_q <= status_d;
      conv_q   <= conv_d;
      oflags_q <= oflags_d;
      owidth_q <= owidth_d;
      oprec_q  <= oprec_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = status_q;
  assign out_o.conv_type       = conv_q;
  assign out_o.zero_pad        = oflags_q[FZero];
  assign out_o.left_align      = oflags_q[FMinus];
  assign out_o.force_sign      = oflags_q[FPlus];
  assign out_o.space_sign      = oflags_q[FSpace];
  assign out_o.alt_form        = oflags_q[FHash];
  assign out_o.field_width     = owidth_q;
  assign out_o.precision_value = oprec_q;

endmodule

>>> rtl/pfs_checker.sv
// ----------------------------------------------------------------------------
// pfs_checker: port-level checks of the printf specifier parser
// Watches the record channel and is bound to the top level.
// ----------------------------------------------------------------------------
module pfs_checker #(
  parameter int unsigned NUM_BITS = pfs_pkg::NUM_BITS_DEFAULT
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [1:0]               status_i,
  input logic [7:0]               conv_type_i,
  input logic                     zero_pad_i,
  input logic                     left_align_i,
  input logic [NUM_BITS-1:0]      field_width_i,
  input logic [NUM_BITS:0]        precision_value_i
);

  // A stalled request keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("record valid dropped while stalled");

  // A stalled request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(conv_type_i)
      && $stable(field_width_i) && $stable(precision_value_i))
    else $error("record payload changed while stalled");

  // A rejected start carries the default record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == pfs_pkg::ST_NOT_START |->
      conv_type_i == 8'd0 && field_width_i == '0 && precision_value_i == '1)
    else $error("not-a-start record is not the default record");

  // A good record always names its conversion letter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == pfs_pkg::ST_OK |-> conv_type_i != 8'd0)
    else $error("good record without conversion letter");

  // Minus always clears zero padding, so both never show together; status is never 3.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(zero_pad_i && left_align_i) && status_i != 2'd3)
    else $error("inconsistent record flags or status");

endmodule

bind printf_spec_parser_top pfs_checker #(.NUM_BITS(NUM_BITS)) u_pfs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .status_i          (out_o.status),
  .conv_type_i       (out_o.conv_type),
  .zero_pad_i        (out_o.zero_pad),
  .left_align_i      (out_o.left_align),
  .field_width_i     (out_o.field_width),
  .precision_value_i (out_o.precision_value)
);
